// ----- hw/rtl/rrt_pkg.sv -----
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and codes for the io range reservation table
// mode and status codes, the table entry layout and the result push word
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

    localparam int PORT_W          = 16;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int DEF_NUM_ENTRIES = 32;

    // command codes
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // one table entry as held in memory
    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] first;
        logic [PORT_W-1:0] last;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // result push from the sequencer to the output stage
    typedef struct packed {
        logic                push;
        logic [STATUS_W-1:0] status;
    } t_rsp_push;

endpackage

`default_nettype wire

// ----- hw/rtl/rrt_if.sv -----
// ----------------------------------------------------------------------------
// rrt_if: valid/ready channels of the io range reservation table
// request channel carries a command word, response channel a status word
// ----------------------------------------------------------------------------
`default_nettype none

interface rrt_req_if;
    logic                       valid;
    logic                       ready;
    logic [rrt_pkg::MODE_W-1:0] mode;
    logic [rrt_pkg::PORT_W-1:0] start_port;
    logic [rrt_pkg::PORT_W-1:0] end_port;

    modport source (output valid, output mode, output start_port, output end_port,
                    input ready);
    modport sink   (input valid, input mode, input start_port, input end_port,
                    output ready);
endinterface

interface rrt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rrt_pkg::STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rrt_mem.sv -----
// ----------------------------------------------------------------------------
// rrt_mem: entry store of the reservation table
// single write port, single read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_mem #(
    parameter int DEPTH = rrt_pkg::DEF_NUM_ENTRIES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire rrt_pkg::t_entry      i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output      rrt_pkg::t_entry      o_rdata
);

    rrt_pkg::t_entry r_mem [DEPTH];
    rrt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/rrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrt_ctrl: scan sequencer of the reservation table
// clears the store after reset, scans all entries per command, then updates
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_ctrl #(
    parameter int NUM_ENTRIES = rrt_pkg::DEF_NUM_ENTRIES,
    parameter int IW          = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command word
    input  wire logic                       i_in_vld,
    output      logic                       o_in_rdy,
    input  wire logic [rrt_pkg::MODE_W-1:0] i_mode,
    input  wire logic [rrt_pkg::PORT_W-1:0] i_start,
    input  wire logic [rrt_pkg::PORT_W-1:0] i_end,
    // output stage
    input  wire logic                       i_slot_free,
    output      rrt_pkg::t_rsp_push         o_rsp,
    // entry store
    output      logic                       o_mem_we,
    output      logic [IW-1:0]              o_mem_waddr,
    output      rrt_pkg::t_entry            o_mem_wdata,
    output      logic                       o_mem_re,
    output      logic [IW-1:0]              o_mem_raddr,
    input  wire rrt_pkg::t_entry            i_mem_rdata
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DECIDE = 5'b10000
    } t_state;

    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic r_rd_vld, n_rd_vld;
    logic r_free_fnd, n_free_fnd;
    logic r_busy, n_busy;
    logic r_match_fnd, n_match_fnd;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [IW-1:0] r_match_idx, n_match_idx;
    logic [rrt_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [rrt_pkg::PORT_W-1:0] r_start, n_start;
    logic [rrt_pkg::PORT_W-1:0] r_end, n_end;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_cnt;
        n_free_fnd  = r_free_fnd;
        n_busy      = r_busy;
        n_match_fnd = r_match_fnd;
        n_free_idx  = r_free_idx;
        n_match_idx = r_match_idx;
        n_mode      = r_mode;
        n_start     = r_start;
        n_end       = r_end;
        o_in_rdy    = 1'b0;
        o_rsp       = '{push: 1'b0, status: rrt_pkg::ST_OK};
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cnt;

        // fold in the entry read in the previous cycle
        if (r_rd_vld) begin
            if (!i_mem_rdata.valid && !r_free_fnd) begin
                n_free_fnd = 1'b1;
                n_free_idx = r_rd_idx;
            end
            if (i_mem_rdata.valid && (r_start <= i_mem_rdata.last)
                    && (i_mem_rdata.first <= r_end)) begin
                n_busy = 1'b1;
            end
            if (i_mem_rdata.valid && (i_mem_rdata.first == r_start)
                    && (i_mem_rdata.last == r_end) && !r_match_fnd) begin
                n_match_fnd = 1'b1;
                n_match_idx = r_rd_idx;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            S_IDLE: begin
                o_in_rdy = 1'b1;
                if (i_in_vld) begin
                    n_mode      = i_mode;
                    n_start     = i_start;
                    n_end       = i_end;
                    n_free_fnd  = 1'b0;
                    n_busy      = 1'b0;
                    n_match_fnd = 1'b0;
                    n_cnt       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_mem_re = 1'b1;
                n_rd_vld = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_slot_free) begin
                    o_rsp.push = 1'b1;
                    n_state    = S_IDLE;
                    unique case (r_mode)
                        rrt_pkg::MODE_REQUEST: begin
                            if (!r_free_fnd) begin
                                o_rsp.status = rrt_pkg::ST_NO_SPACE;
                            end else if (r_busy) begin
                                o_rsp.status = rrt_pkg::ST_BUSY;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_free_idx;
                                o_mem_wdata = '{valid: 1'b1, first: r_start, last: r_end};
                            end
                        end
                        rrt_pkg::MODE_RELEASE: begin
                            if (r_match_fnd) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_match_idx;
                            end else begin
                                o_rsp.status = rrt_pkg::ST_NOT_FOUND;
                            end
                        end
                        rrt_pkg::MODE_CHECK: begin
                            if (r_busy) begin
                                o_rsp.status = rrt_pkg::ST_BUSY;
                            end
                        end
                        default: begin
                            o_rsp.status = rrt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_free_fnd  <= 1'b0;
            r_busy      <= 1'b0;
            r_match_fnd <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_free_fnd  <= n_free_fnd;
            r_busy      <= n_busy;
            r_match_fnd <= n_match_fnd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_free_idx  <= n_free_idx;
        r_match_idx <= n_match_idx;
        r_mode      <= n_mode;
        r_start     <= n_start;
        r_end       <= n_end;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/io_range_reservation_table_top.sv -----
// response: after accept the sequencer scans, drains and decides, then pushes
//   the status word into the output register once the output slot is free
// commands: one at a time; none is taken until the last status word is pushed,
//   and the scan reads one table entry per cycle through the single read port
// reset: synchronous active-low; afterwards a clearing pass writes every
//   entry invalid while the command channel is not ready
// ----------------------------------------------------------------------------
// io_range_reservation_table_top: table of reserved inclusive port ranges
// request, release or check a port range against the reserved entries
// ----------------------------------------------------------------------------
`default_nettype none

module io_range_reservation_table_top #(
    parameter int NUM_ENTRIES = rrt_pkg::DEF_NUM_ENTRIES
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    rrt_req_if.sink  i_req,
    rrt_rsp_if.source o_rsp
);

    // entry index width
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // store port wires
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    rrt_pkg::t_entry mem_wdata;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    rrt_pkg::t_entry mem_rdata;

    // sequencer to output stage
    rrt_pkg::t_rsp_push rsp_push;
    logic               slot_free;

    // output register: one status word that may wait on a stalled sink
    logic                         r_out_vld;
    logic [rrt_pkg::STATUS_W-1:0] r_out_status;

    // the slot frees in the same cycle the waiting word is taken
    assign slot_free = !r_out_vld || o_rsp.ready;

    rrt_mem #(
        .DEPTH (NUM_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // scan sequencer: clearing pass, per-command scan, final update
    rrt_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IW          (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (i_req.valid),
        .o_in_rdy    (i_req.ready),
        .i_mode      (i_req.mode),
        .i_start     (i_req.start_port),
        .i_end       (i_req.end_port),
        .i_slot_free (slot_free),
        .o_rsp       (rsp_push),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // output valid: set on push, cleared when taken with nothing new
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (rsp_push.push) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // status payload, loaded only on push
    always_ff @(posedge i_clk) begin
        if (rsp_push.push) begin
            r_out_status <= rsp_push.status;
        end
    end

    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;

endmodule

`default_nettype wire

// ----- hw/rtl/rrt_checker.sv -----
// ----------------------------------------------------------------------------
// rrt_checker: port-level checks of the io range reservation table
// bound to the top level, watches the command and status channels
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_vld,
    input wire logic                         i_in_rdy,
    input wire logic                         i_out_vld,
    input wire logic                         i_out_rdy,
    input wire logic [rrt_pkg::STATUS_W-1:0] i_out_status
);

    // a stalled status word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_out_status))
        else $error("status word changed or dropped while stalled");

    // the clearing pass keeps the command channel closed after reset
    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_rdy)
        else $error("command accepted during clearing pass");

    // one command at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_vld && i_in_rdy |=> !i_in_rdy)
        else $error("second command accepted while one is in flight");

    // a status word appears only while a command is in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_vld) |-> $past(!i_in_rdy))
        else $error("status word without a command in flight");

endmodule

bind io_range_reservation_table_top rrt_checker u_rrt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_vld     (i_req.valid),
    .i_in_rdy     (i_req.ready),
    .i_out_vld    (o_rsp.valid),
    .i_out_rdy    (o_rsp.ready),
    .i_out_status (o_rsp.status)
);

`default_nettype wire

// ----- tb/sv/io_range_reservation_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// io_range_reservation_table_checker: status prediction and scoreboard
// keeps its own copy of the reservation table, predicts one status word per
// accepted command word and compares the status words in arrival order
// ----------------------------------------------------------------------------
module io_range_reservation_table_checker #(
    parameter int NUM_ENTRIES = rrt_pkg::DEF_NUM_ENTRIES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrt_req_if        i_req,
    rrt_rsp_if        i_rsp,
    output int        o_errors,
    output int        o_words_checked
);

    logic                         tbl_valid [NUM_ENTRIES];
    logic [rrt_pkg::PORT_W-1:0]   tbl_first [NUM_ENTRIES];
    logic [rrt_pkg::PORT_W-1:0]   tbl_last  [NUM_ENTRIES];
    logic [rrt_pkg::STATUS_W-1:0] status_q[$];

    // inclusive overlap against every held range
    function automatic bit span_taken(logic [rrt_pkg::PORT_W-1:0] s,
                                      logic [rrt_pkg::PORT_W-1:0] e);
        int k;
        for (k = 0; k < NUM_ENTRIES; k++) begin
            if (tbl_valid[k] && s <= tbl_last[k] && tbl_first[k] <= e) return 1'b1;
        end
        return 1'b0;
    endfunction

    // status of one command word, table updated as the block would
    function automatic logic [rrt_pkg::STATUS_W-1:0] apply_command(
            logic [rrt_pkg::MODE_W-1:0] m,
            logic [rrt_pkg::PORT_W-1:0] s,
            logic [rrt_pkg::PORT_W-1:0] e);
        int k;
        int slot;
        slot = -1;
        case (m)
            rrt_pkg::MODE_REQUEST: begin
                for (k = NUM_ENTRIES - 1; k >= 0; k--) begin
                    if (!tbl_valid[k]) slot = k;
                end
                // a full table wins over an overlap
                if (slot < 0) return rrt_pkg::ST_NO_SPACE;
                if (span_taken(s, e)) return rrt_pkg::ST_BUSY;
                tbl_valid[slot] = 1'b1;
                tbl_first[slot] = s;
                tbl_last[slot]  = e;
                return rrt_pkg::ST_OK;
            end
            rrt_pkg::MODE_RELEASE: begin
                for (k = 0; k < NUM_ENTRIES; k++) begin
                    if (tbl_valid[k] && tbl_first[k] == s && tbl_last[k] == e) begin
                        tbl_valid[k] = 1'b0;
                        return rrt_pkg::ST_OK;
                    end
                end
                return rrt_pkg::ST_NOT_FOUND;
            end
            rrt_pkg::MODE_CHECK: begin
                return span_taken(s, e) ? rrt_pkg::ST_BUSY : rrt_pkg::ST_OK;
            end
            default: begin
                return rrt_pkg::ST_OK;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        logic [rrt_pkg::STATUS_W-1:0] want;
        int k;
        if (!i_rst_n) begin
            for (k = 0; k < NUM_ENTRIES; k++) tbl_valid[k] = 1'b0;
            status_q.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                status_q.push_back(apply_command(i_req.mode, i_req.start_port,
                                                 i_req.end_port));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                o_words_checked++;
                if (status_q.size() == 0) begin
                    o_errors++;
                    $error("status word with nothing pending: expected none, actual %0d",
                           i_rsp.status);
                end else begin
                    want = status_q.pop_front();
                    if (i_rsp.status !== want) begin
                        o_errors++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want, i_rsp.status);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/io_range_reservation_table_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// io_range_reservation_table_top_tb: testbench of the io range reservation table
// directed corner commands, then random blocks that fill, churn and drain the
// table under random idling and long output stalls; the checker beside the
// block predicts every status word
// ----------------------------------------------------------------------------
module io_range_reservation_table_top_tb;

    localparam int NUM_ENTRIES = rrt_pkg::DEF_NUM_ENTRIES;
    localparam int PORT_W      = rrt_pkg::PORT_W;
    localparam int MODE_W      = rrt_pkg::MODE_W;

    // mode value with no command behind it, answered with ok
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int WORDS_TOTAL      = 1150;
    localparam int CALM_AFTER       = 1000;   // no idling from here on
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HISTORY_DEPTH    = 96;
    localparam int DRAIN_CYCLES     = 2 * (NUM_ENTRIES + 3);
    // bound on the run: every word plus the long receiver holds and the clearing pass
    localparam int CYCLE_LIMIT      = 500000;

    typedef struct packed {
        logic [PORT_W-1:0] first;
        logic [PORT_W-1:0] last;
    } t_span;

    // block kinds of the random part
    typedef enum int {
        BLK_FILL,
        BLK_MIXED,
        BLK_DRAIN
    } t_block;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic rsp_ready = 1'b0;

    int errors;
    int words_checked;
    int words_sent    = 0;
    int gap_pct       = 0;   // chance of a sender gap before a word
    int rsp_stall_pct = 0;   // chance of a receiver stall burst per cycle
    int hold_requests = 0;   // bumped by stimulus to ask for a long receiver hold
    int holds_done    = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int cycle_cnt     = 0;

    // the last HISTORY_DEPTH requested ranges, source of exact releases and overlaps
    t_span span_hist[$];

    rrt_req_if req_if ();
    rrt_rsp_if rsp_if ();

    assign rsp_if.ready = rsp_ready;

    io_range_reservation_table_top #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    io_range_reservation_table_checker #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) status_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req           (req_if),
        .i_rsp           (rsp_if),
        .o_errors        (errors),
        .o_words_checked (words_checked)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: long holds on request, otherwise random stall bursts
    always @(posedge clk) begin
        if (hold_requests != holds_done) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD_CYCLES;
        end
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
        end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic t_span mk_span(logic [PORT_W-1:0] f, logic [PORT_W-1:0] l);
        t_span sp;
        sp.first = f;
        sp.last  = l;
        return sp;
    endfunction

    // mix of wide, narrow, reversed, extreme and overlapping ranges
    function automatic t_span random_span();
        t_span       sp;
        int unsigned style;
        int unsigned lo;
        int unsigned hi;
        style = $urandom_range(0, 99);
        lo    = $urandom_range(0, 65535);
        if (style < 20) begin
            sp.first = lo[PORT_W-1:0];
            sp.last  = PORT_W'($urandom_range(0, 65535));
        end else if (style < 55) begin
            hi       = lo + $urandom_range(0, 63);
            sp.first = lo[PORT_W-1:0];
            sp.last  = (hi > 65535) ? 16'hFFFF : hi[PORT_W-1:0];
        end else if (style < 85 && span_hist.size() != 0) begin
            sp = span_hist[$urandom_range(0, span_hist.size() - 1)];
            // half the time shift the start so it no longer matches, often still overlapping
            if ($urandom_range(0, 1)) sp.first = PORT_W'(sp.first + $urandom_range(1, 8));
        end else if (style < 90) begin
            sp.first = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            sp.last  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            // reversed: start above end
            hi       = lo + $urandom_range(1, 63);
            sp.last  = lo[PORT_W-1:0];
            sp.first = (hi > 65535) ? 16'hFFFF : hi[PORT_W-1:0];
        end
        return sp;
    endfunction

    // a range exactly as asked for earlier, or a random one while none is known
    function automatic t_span known_span();
        if (span_hist.size() == 0) return random_span();
        return span_hist[$urandom_range(0, span_hist.size() - 1)];
    endfunction

    // offer one command word, optionally after a gap, and wait for its accept
    task automatic send_word(input logic [MODE_W-1:0] m, input t_span sp);
        int unsigned gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 10);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= m;
        req_if.start_port <= sp.first;
        req_if.end_port   <= sp.last;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        words_sent++;
        if (m == rrt_pkg::MODE_REQUEST) begin
            span_hist.push_back(sp);
            if (span_hist.size() > HISTORY_DEPTH) void'(span_hist.pop_front());
        end
    endtask

    // stop offering until every status word is back
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (words_checked != words_sent) @(posedge clk);
    endtask

    initial begin : stimulus
        t_span       sp;
        t_block      kind;
        int unsigned r;
        int unsigned w;
        int unsigned lo;
        int          blk_idx;
        int          len;
        int          win_off;
        int          i;

        req_if.valid      <= 1'b0;
        req_if.mode       <= rrt_pkg::MODE_REQUEST;
        req_if.start_port <= '0;
        req_if.end_port   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners, table empty after reset
        send_word(rrt_pkg::MODE_CHECK,   mk_span(16'h0000, 16'hFFFF));  // free
        send_word(rrt_pkg::MODE_RELEASE, mk_span(16'h0000, 16'h0000));  // not found
        send_word(rrt_pkg::MODE_REQUEST, mk_span(16'h0000, 16'h0000));
        send_word(rrt_pkg::MODE_REQUEST, mk_span(16'hFFFF, 16'hFFFF));
        send_word(rrt_pkg::MODE_CHECK,   mk_span(16'h0000, 16'h0000));  // busy
        send_word(rrt_pkg::MODE_REQUEST, mk_span(16'h0000, 16'hFFFF));  // overlaps both
        // reversed range passes the overlap rule and is stored as given
        send_word(rrt_pkg::MODE_REQUEST, mk_span(16'd100, 16'd50));
        send_word(rrt_pkg::MODE_CHECK,   mk_span(16'd40, 16'd120));     // hits reversed entry
        send_word(rrt_pkg::MODE_CHECK,   mk_span(16'd60, 16'd90));      // misses it
        send_word(rrt_pkg::MODE_CHECK,   mk_span(16'hFFFF, 16'h0000));
        send_word(rrt_pkg::MODE_RELEASE, mk_span(16'd50, 16'd100));     // ports swapped
        send_word(rrt_pkg::MODE_RELEASE, mk_span(16'd100, 16'd50));
        send_word(MODE_UNUSED,           mk_span(16'hFFFF, 16'hFFFF));  // ignored
        send_word(rrt_pkg::MODE_REQUEST, mk_span(16'h0001, 16'hFFFE));
        send_word(rrt_pkg::MODE_RELEASE, mk_span(16'h0000, 16'h0000));
        send_word(rrt_pkg::MODE_REQUEST, mk_span(16'h0000, 16'h0000));  // refills lowest
        send_word(rrt_pkg::MODE_RELEASE, mk_span(16'h0001, 16'hFFFE));
        send_word(rrt_pkg::MODE_CHECK,   mk_span(16'h5555, 16'hAAAA));
        wait_for_results();

        // random blocks
        blk_idx = 0;
        while (words_sent < WORDS_TOTAL) begin
            if (words_sent >= CALM_AFTER) begin
                gap_pct       = 0;
                rsp_stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: rsp_stall_pct = 0;
                    1: rsp_stall_pct = 15;
                    default: rsp_stall_pct = 40;
                endcase
            end
            // long receiver hold while words keep coming, fills the block up
            if (blk_idx == 3 || blk_idx == 10) hold_requests++;
            if (blk_idx == 6) wait_for_results();

            kind    = (blk_idx == 0) ? BLK_FILL : t_block'($urandom_range(0, 2));
            len     = $urandom_range(30, 80);
            win_off = $urandom_range(0, 31);
            for (i = 0; i < len && words_sent < WORDS_TOTAL; i++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    BLK_FILL: begin
                        if (r < 15) begin
                            // overlap attempt, no-space once the table is full
                            send_word(rrt_pkg::MODE_REQUEST, known_span());
                        end else begin
                            // one 2048-port window per word keeps each run of 32 such words disjoint
                            w  = (win_off + i) % 32;
                            lo = w * 2048 + $urandom_range(0, 1023);
                            sp.first = lo[PORT_W-1:0];
                            sp.last  = PORT_W'(lo + $urandom_range(0, 1023));
                            if (r > 90) sp = mk_span(sp.last, sp.first);
                            send_word(rrt_pkg::MODE_REQUEST, sp);
                        end
                    end
                    BLK_MIXED: begin
                        if (r < 40)
                            send_word(rrt_pkg::MODE_REQUEST, random_span());
                        else if (r < 58)
                            send_word(rrt_pkg::MODE_RELEASE, known_span());
                        else if (r < 65)
                            send_word(rrt_pkg::MODE_RELEASE, random_span());
                        else if (r < 98)
                            send_word(rrt_pkg::MODE_CHECK, random_span());
                        else
                            send_word(MODE_UNUSED, random_span());
                    end
                    default: begin
                        if (r < 68)
                            send_word(rrt_pkg::MODE_RELEASE, known_span());
                        else if (r < 75)
                            send_word(rrt_pkg::MODE_RELEASE, random_span());
                        else if (r < 90)
                            send_word(rrt_pkg::MODE_CHECK, random_span());
                        else
                            send_word(rrt_pkg::MODE_REQUEST, random_span());
                    end
                endcase
            end
            blk_idx++;
        end

        // drain and let the block settle
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && words_checked == words_sent) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rrt_pkg.sv
hw/rtl/rrt_if.sv
hw/rtl/rrt_mem.sv
hw/rtl/rrt_ctrl.sv
hw/rtl/io_range_reservation_table_top.sv
hw/rtl/rrt_checker.sv
tb/sv/io_range_reservation_table_checker.sv
tb/sv/io_range_reservation_table_top_tb.sv
